// File: sv/rrtu_pkg.sv
// Shared types, codes and tables for the I/O, RAM and interval timer unit.
package rrtu_pkg;

	localparam logic [1:0] REQ_READ  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;

	localparam logic [6:0] ADDR_PORT_LAST = 7'd3;
	localparam logic [6:0] ADDR_PORT_A    = 7'd0;
	localparam logic [6:0] ADDR_TMR_FIRST = 7'd4;
	localparam logic [6:0] ADDR_TMR_LAST  = 7'd7;
	localparam logic [6:0] ADDR_TMR_CNT   = 7'd6;
	localparam logic [6:0] ADDR_TMR_CNT2  = 7'd14;
	localparam logic [6:0] ADDR_TMR_IRQ   = 7'd7;

	localparam logic [7:0] IRQ_BYTE  = 8'h80;
	localparam logic [7:0] BYTE_ONES = 8'hff;
	localparam logic [4:0] KEYS_PER_ROW = 5'd7;

	typedef struct packed {
		logic [1:0] req_type;
		logic [6:0] address;
		logic [7:0] write_data;
		logic [4:0] key_code;
	} req_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       timer_irq;
	} rsp_t;

	// log2 of the prescale selected by timer offsets 4..7 (1, 8, 64, 1024)
	function automatic logic [3:0] prescale_shift(input logic [1:0] sel);
		logic [3:0] sh;
		case (sel)
			2'd0: sh = 4'd0;
			2'd1: sh = 4'd3;
			2'd2: sh = 4'd6;
			default: sh = 4'd10;
		endcase
		return sh;
	endfunction

	function automatic logic [7:0] key_col(input logic [2:0] pos);
		logic [7:0] m;
		case (pos)
			3'd0: m = 8'hbf;
			3'd1: m = 8'hdf;
			3'd2: m = 8'hef;
			3'd3: m = 8'hf7;
			3'd4: m = 8'hfb;
			3'd5: m = 8'hfd;
			3'd6: m = 8'hfe;
			default: m = 8'hff;
		endcase
		return m;
	endfunction

	function automatic logic [7:0] keypad_mask(input logic [3:0] row, input logic [4:0] key);
		logic [4:0] base;
		logic [4:0] off;
		logic [7:0] m;
		base = 5'(row) * KEYS_PER_ROW;
		off  = key - base;
		if (row <= 4'd2) begin
			if (key >= base && off < KEYS_PER_ROW) m = key_col(off[2:0]);
			else m = BYTE_ONES;
		end else if (row == 4'd3) begin
			m = BYTE_ONES;
		end else begin
			m = IRQ_BYTE;
		end
		return m;
	endfunction

endpackage

// File: sv/rrtu_stream_if.sv
// Valid/ready channel carrying one payload of type T per transaction.
interface rrtu_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: sv/rrtu_ram.sv
// Generic single-port RAM with registered read data.
module rrtu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) mem[addr] <= wdata;
			else rdata <= mem[addr];
		end
	end
endmodule

// File: sv/rom_ram_io_timer_unit.sv
// Top level of the I/O, RAM and interval timer unit.
//
// Channels: req carries one bus read, bus write or timer tick per transaction;
// rsp returns exactly one result (read byte, timer flag) per request, in order.
// cfg writes the one-bit variant register; it is always ready. The user must
// write it only while no request is in flight; the block does not enforce this.
// A request accepted from req is registered in the middle stage, and its result
// is then registered in the output register. Throughput: one request per cycle
// while rsp is not stalled, set by the single-port RAM access at accept time and
// one pass through the timer/port logic in the following stage.
// When rsp is stalled the output register holds, the middle stage holds, and
// req.ready drops once both are full; nothing is dropped.
// Reset clears ports, timer, variant and the RAM valid bits (unwritten RAM
// bytes read as zero), so no clearing pass is needed.
module rom_ram_io_timer_unit
	import rrtu_pkg::*;
#(
	parameter int RAM_DEPTH = 64
) (
	input  logic   clk,
	input  logic   arst_n,
	rrtu_stream_if.sink   cfg,
	rrtu_stream_if.sink   req,
	rrtu_stream_if.source rsp
);
	localparam int AW = $clog2(RAM_DEPTH);
	localparam int IW = 6;
	localparam int XW = (AW > IW) ? AW : IW;

	logic           variant_q;
	logic [7:0]     port_q [4];
	logic           run_q;
	logic [1:0]     psel_q;
	logic [7:0]     start_q;
	logic [7:0]     count_q;
	logic           flag_q;
	logic [17:0]    elapsed_q;
	logic [RAM_DEPTH-1:0] ram_vld_q;

	logic           vld_s1;
	req_t           item_s1;
	logic           ram_ok_s1;
	logic           rsp_vld_q;
	rsp_t           rsp_q;

	logic           adv;
	logic           accept;
	req_t           in;
	logic [XW-1:0]  idx_x;
	logic [AW-1:0]  ram_addr;
	logic           in_range;
	logic           ram_en;
	logic [7:0]     ram_rdata;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) variant_q <= 1'b0;
		else if (cfg.valid) variant_q <= cfg.data;
	end

	assign adv       = vld_s1 && (!rsp_vld_q || rsp.ready);
	assign req.ready = !vld_s1 || adv;
	assign accept    = req.valid && req.ready;
	assign in        = req.data;

	assign idx_x    = XW'(in.address[IW-1:0]);
	assign ram_addr = idx_x[AW-1:0];
	assign in_range = in.address[6] && (32'(in.address[IW-1:0]) < RAM_DEPTH);
	assign ram_en   = accept && in_range &&
		(in.req_type == REQ_READ || in.req_type == REQ_WRITE);

	rrtu_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_ram (
		.clk   (clk),
		.en    (ram_en),
		.we    (in.req_type == REQ_WRITE),
		.addr  (ram_addr),
		.wdata (in.write_data),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_vld_q <= '0;
		end else if (ram_en && in.req_type == REQ_WRITE) begin
			ram_vld_q[ram_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req.ready) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1   <= in;
			ram_ok_s1 <= in_range && ram_vld_q[ram_addr];
		end
	end

	// stage 1: register file, RAM read select, keypad and timer
	logic [7:0]  rd;
	logic        run_d;
	logic [1:0]  psel_d;
	logic [7:0]  start_d;
	logic [7:0]  count_d;
	logic        flag_d;
	logic [17:0] elapsed_d;
	logic [3:0]  sh;
	logic [17:0] tick_e;
	logic [17:0] limit;
	logic [17:0] quot;
	logic [6:0]  a;

	assign a      = item_s1.address;
	assign sh     = prescale_shift(psel_q);
	assign tick_e = elapsed_q + 18'd1;
	assign limit  = 18'(start_q) << sh;
	assign quot   = tick_e >> sh;

	always_comb begin
		rd        = '0;
		run_d     = run_q;
		psel_d    = psel_q;
		start_d   = start_q;
		count_d   = count_q;
		flag_d    = flag_q;
		elapsed_d = elapsed_q;
		case (item_s1.req_type)
			REQ_READ: begin
				if (a[6]) begin
					rd = ram_ok_s1 ? ram_rdata : 8'd0;
				end else if (a <= ADDR_PORT_LAST) begin
					if (a == ADDR_PORT_A && !variant_q)
						rd = keypad_mask(port_q[2][4:1], item_s1.key_code);
					else
						rd = port_q[a[1:0]];
				end else if (a == ADDR_TMR_CNT || a == ADDR_TMR_CNT2) begin
					if (!flag_q) begin
						rd = count_q;
					end else begin
						flag_d    = 1'b0;
						elapsed_d = '0;
						count_d   = variant_q ? BYTE_ONES : start_q;
					end
				end else if (a == ADDR_TMR_IRQ) begin
					rd = flag_q ? IRQ_BYTE : 8'd0;
				end
			end
			REQ_WRITE: begin
				if (!a[6] && a >= ADDR_TMR_FIRST && a <= ADDR_TMR_LAST) begin
					run_d     = 1'b1;
					psel_d    = a[1:0];
					flag_d    = 1'b0;
					start_d   = item_s1.write_data;
					count_d   = item_s1.write_data;
					elapsed_d = '0;
				end
			end
			REQ_TICK: begin
				if (run_q && !flag_q) begin
					elapsed_d = tick_e;
					if (limit <= tick_e) begin
						flag_d  = 1'b1;
						count_d = 8'd0;
					end else begin
						count_d = start_q - quot[7:0];
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q     <= 1'b0;
			psel_q    <= 2'd0;
			start_q   <= 8'd0;
			count_q   <= 8'd0;
			flag_q    <= 1'b0;
			elapsed_q <= '0;
			for (int i = 0; i < 4; i++) port_q[i] <= 8'd0;
		end else if (adv) begin
			run_q     <= run_d;
			psel_q    <= psel_d;
			start_q   <= start_d;
			count_q   <= count_d;
			flag_q    <= flag_d;
			elapsed_q <= elapsed_d;
			if (item_s1.req_type == REQ_WRITE && a <= ADDR_PORT_LAST)
				port_q[a[1:0]] <= item_s1.write_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (adv) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q.read_data <= rd;
			rsp_q.timer_irq <= flag_d;
		end
	end

	assign rsp.valid = rsp_vld_q;
	assign rsp.data  = rsp_q;
endmodule
